// File: design/rtmf_pkg.sv
package rtmf_pkg;

	localparam int RANGE_W  = 16;
	localparam int STATUS_W = 8;
	localparam int SAMPLE_W = 13;
	localparam int DIST_W   = 17;
	localparam int TRIM_W   = 2;
	localparam int LIMIT_W  = 8;
	localparam int RUN_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_BITS = 4;
	localparam int TRIM_MAX  = 3;

	localparam logic [STATUS_W-1:0] STATUS_PHASE_FAIL = 8'd4;

	localparam logic [CFG_IDX_W-1:0] REG_OOR_MM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_MM  = 2'd3;

	localparam logic [SAMPLE_W-1:0] OOR_MM_RESET  = 13'd8190;
	localparam logic [TRIM_W-1:0]   TRIM_RESET    = 2'd1;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = 8'd3;
	localparam logic [SAMPLE_W-1:0] WALL_MM_RESET = 13'd150;
	localparam logic [RUN_W-1:0]    RUN_MAX       = 8'd255;

	// One word from the sample memory as seen by the statistics unit.
	typedef struct packed {
		logic                clear;
		logic                take;
		logic [SAMPLE_W-1:0] data;
	} scan_t;

endpackage

// File: design/rtmf_ram.sv
module rtmf_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/rtmf_stats.sv
module rtmf_stats #(
	parameter int CW = 4,
	parameter int SW = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rtmf_pkg::scan_t             scan,
	input  logic                        finish,
	input  logic [rtmf_pkg::TRIM_W-1:0] trim_cnt,
	output logic [SW-1:0]               total_q,
	output logic [SW-1:0]               trim_sum_q,
	output logic [CW-1:0]               used_q
);

	localparam int EW = CW + 3;

	logic [rtmf_pkg::SAMPLE_W-1:0] lo_q [rtmf_pkg::TRIM_MAX];
	logic [rtmf_pkg::SAMPLE_W-1:0] hi_q [rtmf_pkg::TRIM_MAX];
	logic [CW-1:0]                 n_q;

	logic [rtmf_pkg::SAMPLE_W-1:0] v;
	logic                          trim_ok;
	logic [rtmf_pkg::TRIM_W-1:0]   t_eff;
	logic [SW-1:0]                 tsum;
	logic [SW-1:0]                 pair0, pair1, pair2;

	assign v = scan.data;

	// The trimmed set only exists once there are more than 2*trim+2 samples.
	assign trim_ok = EW'(n_q) > (EW'({trim_cnt, 1'b0}) + EW'(2));
	assign t_eff   = trim_ok ? trim_cnt : '0;

	assign pair0 = SW'(lo_q[0]) + SW'(hi_q[0]);
	assign pair1 = SW'(lo_q[1]) + SW'(hi_q[1]);
	assign pair2 = SW'(lo_q[2]) + SW'(hi_q[2]);

	always_comb begin
		case (t_eff)
			2'd0: tsum = '0;
			2'd1: tsum = pair0;
			2'd2: tsum = pair0 + pair1;
			default: tsum = pair0 + pair1 + pair2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= '0;
			total_q    <= '0;
			trim_sum_q <= '0;
			used_q     <= '0;
			for (int i = 0; i < rtmf_pkg::TRIM_MAX; i++) begin
				lo_q[i] <= '1;
				hi_q[i] <= '0;
			end
		end else if (scan.clear) begin
			n_q     <= '0;
			total_q <= '0;
			for (int i = 0; i < rtmf_pkg::TRIM_MAX; i++) begin
				lo_q[i] <= '1;
				hi_q[i] <= '0;
			end
		end else if (scan.take) begin
			n_q     <= n_q + CW'(1);
			total_q <= total_q + SW'(v);
			// Keep the three smallest in ascending and three largest in descending order.
			lo_q[0] <= (v < lo_q[0]) ? v : lo_q[0];
			lo_q[1] <= (v < lo_q[0]) ? lo_q[0] : ((v < lo_q[1]) ? v : lo_q[1]);
			lo_q[2] <= (v < lo_q[1]) ? lo_q[1] : ((v < lo_q[2]) ? v : lo_q[2]);
			hi_q[0] <= (v > hi_q[0]) ? v : hi_q[0];
			hi_q[1] <= (v > hi_q[0]) ? hi_q[0] : ((v > hi_q[1]) ? v : hi_q[1]);
			hi_q[2] <= (v > hi_q[1]) ? hi_q[1] : ((v > hi_q[2]) ? v : hi_q[2]);
		end else if (finish) begin
			trim_sum_q <= tsum;
			used_q     <= n_q - CW'({t_eff, 1'b0});
		end
	end

endmodule

// File: design/rtmf_div.sv
module rtmf_div #(
	parameter int DW = 21,
	parameter int VW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int NW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;

	logic [VW:0]   rem_shift;
	logic [VW+1:0] diff;
	logic          ge;

	// Restoring division, one quotient bit per cycle.
	assign rem_shift = {rem_q, quo_q[DW-1]};
	assign diff      = {1'b0, rem_shift} - {2'b0, div_q};
	assign ge        = !diff[VW+1];
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(DW);
				quo_q  <= dividend;
				rem_q  <= '0;
				div_q  <= divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[DW-2:0], ge};
				rem_q <= ge ? diff[VW-1:0] : rem_shift[VW-1:0];
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

// File: design/range_trimmed_mean_filter_core.sv
// Channel  | Handshake              | Word
// ---------+------------------------+---------------------------------------------
// in       | in_valid / in_ready    | first and retry range, status, timeout
// out      | out_valid / out_ready  | distance_q4, out_of_range, is_wall
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// A valid sample makes one pass over the sample memory through its single read port, then
// runs a restoring divider producing one quotient bit per cycle. An invalid word skips both
// and goes straight to the result stage. One word is worked on at a time; the result register
// lets the next word in while a result still waits. Reset marks every memory entry empty at once.
module range_trimmed_mean_filter_core #(
	parameter int RING_DEPTH = 9
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rtmf_pkg::RANGE_W-1:0]          first_range_mm,
	input  logic [rtmf_pkg::STATUS_W-1:0]         first_status,
	input  logic                                  first_timeout,
	input  logic [rtmf_pkg::RANGE_W-1:0]          retry_range_mm,
	input  logic [rtmf_pkg::STATUS_W-1:0]         retry_status,
	input  logic                                  retry_timeout,

	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [rtmf_pkg::DIST_W-1:0]           distance_q4,
	output logic                                  out_of_range,
	output logic                                  is_wall,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rtmf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rtmf_pkg::SAMPLE_W-1:0]         cfg_data
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int SW = rtmf_pkg::SAMPLE_W + CW;
	localparam int DW = SW + rtmf_pkg::FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_TRIM = 3'd2;
	localparam logic [2:0] ST_DGO  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;

	logic [rtmf_pkg::SAMPLE_W-1:0] oor_mm_q;
	logic [rtmf_pkg::TRIM_W-1:0]   trim_q;
	logic [rtmf_pkg::LIMIT_W-1:0]  limit_q;
	logic [rtmf_pkg::SAMPLE_W-1:0] wall_mm_q;

	logic [RING_DEPTH-1:0]         valid_q;
	logic [AW-1:0]                 slot_q;
	logic [rtmf_pkg::RUN_W-1:0]    run_q;
	logic [rtmf_pkg::DIST_W-1:0]   held_q;
	logic                          held_oor_q;

	logic [CW-1:0]                 scan_q;
	logic                          rd_issue_s1;
	logic                          rd_valid_s1;

	logic                          accept;
	logic                          first_ok;
	logic                          pick_ok;
	logic [rtmf_pkg::RANGE_W-1:0]  pick_range;
	logic                          sample_ok;
	logic [rtmf_pkg::SAMPLE_W-1:0] sample;
	logic [rtmf_pkg::RUN_W-1:0]    run_next;
	logic                          issue;

	logic [rtmf_pkg::SAMPLE_W-1:0] rd_data;
	rtmf_pkg::scan_t               scan;
	logic [SW-1:0]                 total;
	logic [SW-1:0]                 trim_sum;
	logic [CW-1:0]                 used;
	logic [SW-1:0]                 kept_sum;
	logic                          div_done;
	logic [DW-1:0]                 quotient;

	logic [rtmf_pkg::DIST_W-1:0]   res_dist;
	logic [rtmf_pkg::DIST_W-1:0]   wall_q4;
	logic                          out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	// The retry only stands in when the first reading failed outright, not when it is too far.
	assign first_ok   = !first_timeout && (first_status != rtmf_pkg::STATUS_PHASE_FAIL);
	assign pick_range = first_ok ? first_range_mm : retry_range_mm;
	assign pick_ok    = first_ok ||
		(!retry_timeout && (retry_status != rtmf_pkg::STATUS_PHASE_FAIL));
	assign sample_ok  = pick_ok && (pick_range < rtmf_pkg::RANGE_W'(oor_mm_q));
	assign sample     = pick_range[rtmf_pkg::SAMPLE_W-1:0];
	assign run_next   = (run_q == rtmf_pkg::RUN_MAX) ? run_q : run_q + rtmf_pkg::RUN_W'(1);

	assign issue = (state_q == ST_SCAN) && (scan_q < CW'(RING_DEPTH));

	rtmf_ram #(
		.WIDTH(rtmf_pkg::SAMPLE_W),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && sample_ok),
		.waddr(slot_q),
		.wdata(sample),
		.raddr(scan_q[AW-1:0]),
		.rdata(rd_data)
	);

	assign scan.clear = accept && sample_ok;
	assign scan.take  = rd_issue_s1 && rd_valid_s1;
	assign scan.data  = rd_data;

	rtmf_stats #(
		.CW(CW),
		.SW(SW)
	) u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan      (scan),
		.finish    (state_q == ST_TRIM),
		.trim_cnt  (trim_q),
		.total_q   (total),
		.trim_sum_q(trim_sum),
		.used_q    (used)
	);

	assign kept_sum = total - trim_sum;

	rtmf_div #(
		.DW(DW),
		.VW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_DGO),
		.dividend({kept_sum, {rtmf_pkg::FRAC_BITS{1'b0}}}),
		.divisor (used),
		.done    (div_done),
		.quotient(quotient)
	);

	// While out of range the marker follows the current out-of-range distance register.
	assign res_dist = held_oor_q ? {oor_mm_q, {rtmf_pkg::FRAC_BITS{1'b0}}} : held_q;
	assign wall_q4  = {wall_mm_q, {rtmf_pkg::FRAC_BITS{1'b0}}};
	assign out_load = (state_q == ST_FIN) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oor_mm_q  <= rtmf_pkg::OOR_MM_RESET;
			trim_q    <= rtmf_pkg::TRIM_RESET;
			limit_q   <= rtmf_pkg::LIMIT_RESET;
			wall_mm_q <= rtmf_pkg::WALL_MM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rtmf_pkg::REG_OOR_MM:  oor_mm_q  <= cfg_data;
				rtmf_pkg::REG_TRIM:    trim_q    <= cfg_data[rtmf_pkg::TRIM_W-1:0];
				rtmf_pkg::REG_LIMIT:   limit_q   <= cfg_data[rtmf_pkg::LIMIT_W-1:0];
				rtmf_pkg::REG_WALL_MM: wall_mm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			slot_q      <= '0;
			run_q       <= '0;
			held_q      <= '0;
			held_oor_q  <= 1'b1;
			scan_q      <= '0;
			rd_issue_s1 <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_issue_s1 <= issue;
			rd_valid_s1 <= valid_q[scan_q[AW-1:0]];
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sample_ok) begin
							valid_q[slot_q] <= 1'b1;
							slot_q  <= (slot_q == AW'(RING_DEPTH - 1)) ? '0 : slot_q + AW'(1);
							run_q   <= '0;
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							run_q <= run_next;
							if (run_next >= limit_q) begin
								held_oor_q <= 1'b1;
								held_q     <= '0;
								valid_q    <= '0;
								slot_q     <= '0;
							end
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + CW'(1);
					end else if (!rd_issue_s1) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: state_q <= ST_DGO;
				ST_DGO:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						held_q     <= quotient[rtmf_pkg::DIST_W-1:0];
						held_oor_q <= 1'b0;
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			distance_q4  <= res_dist;
			out_of_range <= held_oor_q;
			is_wall      <= !held_oor_q && (res_dist < wall_q4);
		end
	end

endmodule
